>>> rtl/core/antialiased_glyph_row_renderer_core_macros.svh
// ----------------------------------------------------------------------------
// antialiased glyph row renderer assertion macros
// shared concurrent assertion forms used by the renderer core
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_GLYPH_ROW_RENDERER_CORE_MACROS_SVH
`define ANTIALIASED_GLYPH_ROW_RENDERER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define AGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/agr_pkg.sv
// ----------------------------------------------------------------------------
// agr_pkg
// types, codes and channel arithmetic for the glyph row renderer
// ----------------------------------------------------------------------------
package agr_pkg;

    // stream layout
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;

    localparam int FONT_ADDR_LSB = 0;
    localparam int FONT_ADDR_W   = 12;
    localparam int FONT_BYTE_LSB = 12;
    localparam int FONT_BYTE_W   = 8;
    localparam int CHAR_CODE_LSB = 20;
    localparam int CHAR_CODE_W   = 7;
    localparam int GLYPH_ROW_LSB = 27;
    localparam int GLYPH_ROW_W   = 4;

    localparam int PIXEL_W  = 16;
    localparam int COLUMN_W = 3;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FOREGROUND = 1'b0,
        CFG_BACKGROUND = 1'b1
    } t_cfg_index;

    localparam logic [PIXEL_W-1:0] FOREGROUND_RESET = 16'h0000;
    localparam logic [PIXEL_W-1:0] BACKGROUND_RESET = 16'hffff;

    // item kinds carried on tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // glyph geometry
    localparam int GLYPH_W        = 8;
    localparam int GLYPH_H        = 16;
    localparam int GLYPH_IDX_MAX  = 127;
    localparam int PIX_PER_BYTE   = 4;
    localparam logic [CHAR_CODE_W-1:0] CHAR_BASE = 7'd32;
    localparam logic [COLUMN_W-1:0]    LAST_COL  = 3'd7;

    typedef logic [7:0]         t_font_byte;
    typedef logic [PIXEL_W-1:0] t_rgb565;

    // 2-bit atlas code, alpha = 85 * code
    typedef enum logic [1:0] {
        ALPHA_NONE       = 2'd0,
        ALPHA_THIRD      = 2'd1,
        ALPHA_TWO_THIRDS = 2'd2,
        ALPHA_FULL       = 2'd3
    } t_alpha;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb8;

    // weighted channel sums, at most 3 * 255
    typedef struct packed {
        logic [9:0] r;
        logic [9:0] g;
        logic [9:0] b;
    } t_rgb_sum;

    // v * 255 / 31 through a reciprocal, exact for all 5-bit v
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [26:0] p;
        p = 27'(v) * 27'd255 * 27'd8457;
        return p[25:18];
    endfunction

    // v * 255 / 63 through a reciprocal, exact for all 6-bit v
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [28:0] p;
        p = 29'(v) * 29'd255 * 29'd16645;
        return p[27:20];
    endfunction

    // s / 3 for s up to 765
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] p;
        p = 20'(s) * 20'd683;
        return p[18:11];
    endfunction

endpackage

>>> rtl/core/agr_font_ram.sv
// ----------------------------------------------------------------------------
// agr_font_ram
// font atlas storage, one write port and two registered read ports
// ----------------------------------------------------------------------------
module agr_font_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  agr_pkg::t_font_byte  i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr_a,
    input  logic [ADDR_W-1:0]    i_rd_addr_b,
    output agr_pkg::t_font_byte  o_rd_data_a,
    output agr_pkg::t_font_byte  o_rd_data_b
);
    import agr_pkg::*;

    t_font_byte r_mem [DEPTH];
    t_font_byte r_rd_a;
    t_font_byte r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> rtl/core/antialiased_glyph_row_renderer_core.sv
// ----------------------------------------------------------------------------
// antialiased glyph row renderer core
// Holds a 2-bit-per-pixel font atlas and turns one glyph row into eight
// blended RGB565 pixels.
// Input stream: tuser selects a load (writes one atlas byte) or a render
// (one row of one printable character). Output stream: one pixel per
// transfer with its column, tlast on column 7. Loads produce no output.
// Colors are set through the write port (index 0 foreground, 1 background);
// the user must set them only while no render is in flight; the block
// itself does not enforce this. Renders are bound by the one-pixel-per-cycle
// row serializer, so back to back renders sustain one output transfer every
// cycle while the receiver does not stall. Loads are written on their input
// transfer, except that a load right behind a render is held until that
// render has read the atlas; tready then depends on tuser.
// Reset clears all valid bits and the color registers (foreground black,
// background white); atlas contents are kept and are undefined until loaded.
// A receiver stall holds the output register and backs up stage by stage
// to s_axis_tready; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "antialiased_glyph_row_renderer_core_macros.svh"

module antialiased_glyph_row_renderer_core #(
    parameter int FONT_BYTES  = 4096,
    parameter int ATLAS_WIDTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // color register writes
    input  logic                                i_cfg_wr_en,
    input  logic [agr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [agr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // font_addr[11:0], font_byte[19:12], char_code[26:20], glyph_row[30:27]
    input  logic [agr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  logic [agr_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // output pixels
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel[15:0], column[18:16]
    output logic [agr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import agr_pkg::*;

    // atlas geometry, all worked out at elaboration
    localparam int PER_ROW   = ATLAS_WIDTH / GLYPH_W;          // glyphs per atlas band
    localparam int QMAX      = GLYPH_IDX_MAX / PER_ROW;        // last glyph band
    localparam int Q_W       = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
    localparam int LINE_MAX  = QMAX * GLYPH_H + GLYPH_H;       // band top + 1 + row 15
    localparam int LINE_W    = $clog2(LINE_MAX + 1);
    localparam int LINE_BYTES = ATLAS_WIDTH / PIX_PER_BYTE;
    localparam int ROW_BYTES = GLYPH_W / PIX_PER_BYTE;         // two bytes per glyph row
    localparam int BASE_MAX  = LINE_MAX * LINE_BYTES + (PER_ROW - 1) * ROW_BYTES;
    localparam int MEM_AW    = $clog2(FONT_BYTES);
    localparam int BASE_NEED = $clog2(BASE_MAX + 1);
    localparam int BASE_W    = (BASE_NEED > MEM_AW) ? BASE_NEED : MEM_AW;
    localparam int CMP_W     = BASE_W + 1;

    // ------------------------------------------------------------------
    // input field unpack
    // ------------------------------------------------------------------
    logic                     in_cmd;
    logic [FONT_ADDR_W-1:0]   in_font_addr;
    t_font_byte               in_font_byte;
    logic [CHAR_CODE_W-1:0]   in_char_code;
    logic [GLYPH_ROW_W-1:0]   in_glyph_row;
    logic                     in_xfer;

    assign in_cmd       = s_axis_tuser[0];
    assign in_font_addr = s_axis_tdata[FONT_ADDR_LSB +: FONT_ADDR_W];
    assign in_font_byte = s_axis_tdata[FONT_BYTE_LSB +: FONT_BYTE_W];
    assign in_char_code = s_axis_tdata[CHAR_CODE_LSB +: CHAR_CODE_W];
    assign in_glyph_row = s_axis_tdata[GLYPH_ROW_LSB +: GLYPH_ROW_W];
    assign in_xfer      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // color registers and their expanded 8-bit channels
    // ------------------------------------------------------------------
    t_rgb565 r_fg;
    t_rgb565 r_bg;
    t_rgb8   r_fg_exp;
    t_rgb8   r_bg_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FOREGROUND_RESET;
            r_bg <= BACKGROUND_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FOREGROUND: r_fg <= i_cfg_data;
                CFG_BACKGROUND: r_bg <= i_cfg_data;
            endcase
        end
    end

    // refreshed every cycle, settled long before a render reaches the blend
    always_ff @(posedge i_clk) begin
        r_fg_exp <= '{r: expand5(r_fg[15:11]), g: expand6(r_fg[10:5]), b: expand5(r_fg[4:0])};
        r_bg_exp <= '{r: expand5(r_bg[15:11]), g: expand6(r_bg[10:5]), b: expand5(r_bg[4:0])};
    end

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_out_valid;
    logic [COLUMN_W-1:0] r_s4_col;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, out_ready;
    logic s4_emit;
    logic load_hold;

    assign out_ready = !r_out_valid || m_axis_tready;
    assign s5_ready  = !r_s5_valid || out_ready;
    assign s4_emit   = r_s4_valid && s5_ready;
    assign s4_ready  = !r_s4_valid || (s5_ready && (r_s4_col == LAST_COL));
    assign s3_ready  = !r_s3_valid || s4_ready;
    assign s2_ready  = !r_s2_valid || s3_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;

    // a render still ahead of its atlas read after this edge; a load must
    // not overtake it, a load on the read edge itself is fine
    assign load_hold = r_s1_valid || (r_s2_valid && !s3_ready);

    assign s_axis_tready = s1_ready && !((in_cmd == CMD_LOAD) && load_hold);

    // ------------------------------------------------------------------
    // stage 1: glyph index split into atlas band and slot
    // ------------------------------------------------------------------
    logic [CHAR_CODE_W-1:0] glyph;
    logic [Q_W-1:0]         n_s1_q;
    logic [CHAR_CODE_W-1:0] n_s1_rem;
    logic [Q_W-1:0]         r_s1_q;
    logic [CHAR_CODE_W-1:0] r_s1_rem;
    logic [GLYPH_ROW_W-1:0] r_s1_row;

    // control codes wrap into the top glyph slots
    assign glyph = in_char_code - CHAR_BASE;

    always_comb begin
        n_s1_q = '0;
        for (int k = 1; k <= QMAX; k++) begin
            if (glyph >= CHAR_CODE_W'(k * PER_ROW)) begin
                n_s1_q = n_s1_q + Q_W'(1);
            end
        end
        n_s1_rem = glyph - CHAR_CODE_W'(n_s1_q * PER_ROW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= in_xfer && (in_cmd == CMD_RENDER);
            r_s1_q     <= n_s1_q;
            r_s1_rem   <= n_s1_rem;
            r_s1_row   <= in_glyph_row;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: byte address of the row's first pixel
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] line;
    logic [BASE_W-1:0] n_s2_base;
    logic [BASE_W-1:0] r_s2_base;

    // glyphs start one atlas line below their band boundary
    assign line = LINE_W'(r_s1_q) * LINE_W'(GLYPH_H) + LINE_W'(r_s1_row) + LINE_W'(1);
    assign n_s2_base = BASE_W'(line) * BASE_W'(LINE_BYTES) + BASE_W'({r_s1_rem, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
            r_s2_base  <= n_s2_base;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: atlas read of both bytes, range check beside it
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] base_a;
    logic [CMP_W-1:0] base_b;
    logic             mem_wr_en;
    logic             r_s3_oob_a;
    logic             r_s3_oob_b;
    t_font_byte       rd_a;
    t_font_byte       rd_b;

    assign base_a = CMP_W'(r_s2_base);
    assign base_b = base_a + CMP_W'(1);

    // loads write on their input transfer; out-of-range loads are dropped
    assign mem_wr_en = in_xfer && (in_cmd == CMD_LOAD)
                    && (CMP_W'(in_font_addr) < CMP_W'(FONT_BYTES));

    agr_font_ram #(
        .DEPTH  (FONT_BYTES),
        .ADDR_W (MEM_AW)
    ) u_font_ram (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (MEM_AW'(in_font_addr)),
        .i_wr_data   (in_font_byte),
        .i_rd_en     (s3_ready),
        .i_rd_addr_a (base_a[MEM_AW-1:0]),
        .i_rd_addr_b (base_b[MEM_AW-1:0]),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= r_s2_valid;
            r_s3_oob_a <= base_a >= CMP_W'(FONT_BYTES);
            r_s3_oob_b <= base_b >= CMP_W'(FONT_BYTES);
        end
    end

    // ------------------------------------------------------------------
    // stage 4: row serializer, one 2-bit code per cycle while stage 5 accepts, column 0 first
    // ------------------------------------------------------------------
    logic [2*GLYPH_W-1:0] r_s4_codes;
    t_font_byte           byte_a;
    t_font_byte           byte_b;

    // bytes past the atlas read as zero, i.e. foreground
    assign byte_a = r_s3_oob_a ? '0 : rd_a;
    assign byte_b = r_s3_oob_b ? '0 : rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s4_col   <= '0;
        end else if (s4_ready) begin
            r_s4_valid <= r_s3_valid;
            r_s4_col   <= '0;
            r_s4_codes <= {byte_a, byte_b};
        end else if (s4_emit) begin
            r_s4_col   <= r_s4_col + COLUMN_W'(1);
            r_s4_codes <= {r_s4_codes[2*GLYPH_W-3:0], 2'b00};
        end
    end

    // ------------------------------------------------------------------
    // stage 5: weighted channel sums for the two partial alphas
    // ------------------------------------------------------------------
    t_alpha              cur_code;
    t_rgb_sum            n_s5_sum;
    t_alpha              r_s5_code;
    logic [COLUMN_W-1:0] r_s5_col;
    t_rgb_sum            r_s5_sum;

    assign cur_code = t_alpha'(r_s4_codes[2*GLYPH_W-1 -: 2]);

    // alpha 85 blends to (bg + 2 fg) / 3, alpha 170 to (2 bg + fg) / 3
    always_comb begin
        if (cur_code == ALPHA_THIRD) begin
            n_s5_sum.r = 10'(r_bg_exp.r) + {1'b0, r_fg_exp.r, 1'b0};
            n_s5_sum.g = 10'(r_bg_exp.g) + {1'b0, r_fg_exp.g, 1'b0};
            n_s5_sum.b = 10'(r_bg_exp.b) + {1'b0, r_fg_exp.b, 1'b0};
        end else begin
            n_s5_sum.r = {1'b0, r_bg_exp.r, 1'b0} + 10'(r_fg_exp.r);
            n_s5_sum.g = {1'b0, r_bg_exp.g, 1'b0} + 10'(r_fg_exp.g);
            n_s5_sum.b = {1'b0, r_bg_exp.b, 1'b0} + 10'(r_fg_exp.b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (s5_ready) begin
            r_s5_valid <= r_s4_valid;
            r_s5_code  <= cur_code;
            r_s5_col   <= r_s4_col;
            r_s5_sum   <= n_s5_sum;
        end
    end

    // ------------------------------------------------------------------
    // output register: divide by three, repack, or pass a solid color
    // ------------------------------------------------------------------
    t_rgb565             n_out_pixel;
    t_rgb565             r_out_pixel;
    logic [COLUMN_W-1:0] r_out_col;
    logic                r_out_last;
    logic [7:0]          mix_r;
    logic [7:0]          mix_g;
    logic [7:0]          mix_b;

    assign mix_r = div3(r_s5_sum.r);
    assign mix_g = div3(r_s5_sum.g);
    assign mix_b = div3(r_s5_sum.b);

    always_comb begin
        unique case (r_s5_code)
            ALPHA_NONE:       n_out_pixel = r_fg;
            ALPHA_FULL:       n_out_pixel = r_bg;
            ALPHA_THIRD,
            ALPHA_TWO_THIRDS: n_out_pixel = {mix_r[7:3], mix_g[7:2], mix_b[7:3]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s5_valid;
            r_out_pixel <= n_out_pixel;
            r_out_col   <= r_s5_col;
            r_out_last  <= (r_s5_col == LAST_COL);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - PIXEL_W - COLUMN_W)'(0), r_out_col, r_out_pixel};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    logic out_xfer;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // a row in the serializer steps one column per emitted pixel
    `AGR_ASSERT_NEXT(a_ser_step, i_clk, i_rst_n, s4_emit && (r_s4_col != LAST_COL), r_s4_valid && (r_s4_col == $past(r_s4_col) + COLUMN_W'(1)), "serializer column skipped or reloaded mid-row")

    // pixels of a row leave in column order
    `AGR_ASSERT_NEXT(a_out_col_step, i_clk, i_rst_n, out_xfer && !m_axis_tlast, !m_axis_tvalid || (r_out_col == $past(r_out_col) + COLUMN_W'(1)), "output column out of order")

    // the pixel after a row end opens a new row
    `AGR_ASSERT_NEXT(a_out_row_start, i_clk, i_rst_n, out_xfer && m_axis_tlast, !m_axis_tvalid || (r_out_col == '0), "row did not restart at column 0")

    // tlast marks exactly the last column
    `AGR_ASSERT_IMPL(a_last_col, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (r_out_col == LAST_COL), "tlast disagrees with column")

endmodule
